### src/tmpp_pkg.sv
// Shared types and constants of the timed motion program player.
package tmpp_pkg;

  // Input item modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;
  localparam logic [1:0] MODE_TICK  = 2'd3;

  // Program entry kinds; kind 7 plays like pause
  localparam logic [2:0] KIND_FORWARD   = 3'd0;
  localparam logic [2:0] KIND_BACKWARD  = 3'd1;
  localparam logic [2:0] KIND_LEFT      = 3'd2;
  localparam logic [2:0] KIND_RIGHT     = 3'd3;
  localparam logic [2:0] KIND_LIGHT_ON  = 3'd4;
  localparam logic [2:0] KIND_LIGHT_OFF = 3'd5;

  localparam int unsigned ENTRY_W    = 18;
  localparam int unsigned STEP_LIMIT = 64;
  localparam int unsigned MS_W       = 18;

  localparam logic [MS_W-1:0] MS_PER_SECOND  = 18'd1000;
  localparam logic [MS_W-1:0] ELAPSED_MAX    = '1;
  localparam logic [7:0]      LIGHT_ON_LEVEL = 8'd255;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] speed;
    logic [7:0] seconds;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic write;
    logic start;
    logic stop;
    logic tick;
    logic apply;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic advance;
    logic zero_len;
  } status_t;

endpackage

### src/tmpp_ram.sv
// Generic single write port, single read port RAM with registered read.
module tmpp_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/tmpp_ctrl.sv
// Controller: handshakes, sequencing and command generation.
module tmpp_ctrl
  import tmpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  output logic       out_valid,
  input  logic       out_ready,
  input  status_t    status,
  output cmd_t       cmd
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_APPLY = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic done_now;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    done_now  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          done_now = 1'b1;
          unique case (in_mode)
            MODE_WRITE: cmd.write = 1'b1;
            MODE_START: begin
              cmd.start = 1'b1;
              if (!status.zero_len) begin
                done_now  = 1'b0;
                state_nxt = S_APPLY;
              end
            end
            MODE_STOP: cmd.stop = 1'b1;
            MODE_TICK: begin
              cmd.tick = 1'b1;
              if (status.advance) begin
                done_now  = 1'b0;
                state_nxt = S_APPLY;
              end
            end
            default: cmd = '0;
          endcase
        end
      end
      S_APPLY: begin
        // entry data is out of the RAM now
        cmd.apply = 1'b1;
        done_now  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (done_now) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/tmpp_dp.sv
// Datapath: program memory, step timer, wheel drive and headlight registers.
module tmpp_dp
  import tmpp_pkg::*;
#(
  parameter int unsigned PROGRAM_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_program_length,
  input  logic [5:0]        entry_index,
  input  logic [2:0]        entry_kind,
  input  logic [6:0]        entry_speed,
  input  logic [7:0]        entry_seconds,
  output logic signed [7:0] drive_front_right,
  output logic signed [7:0] drive_front_left,
  output logic signed [7:0] drive_back_right,
  output logic signed [7:0] drive_back_left,
  output logic [7:0]        headlight_level,
  output logic [5:0]        step_index,
  output logic              finished
);

  // only the first 64 entries can ever be addressed
  localparam int unsigned MEM_DEPTH = (PROGRAM_DEPTH < STEP_LIMIT) ? PROGRAM_DEPTH
                                                                    : STEP_LIMIT;
  localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [6:0] DEPTH_CAP = 7'(MEM_DEPTH);
  localparam logic [8:0] DEPTH_LIM = 9'(PROGRAM_DEPTH);

  logic [6:0]        len_r, len_nxt;
  logic              running_r, running_nxt;
  logic [5:0]        step_r, step_nxt;
  logic [MS_W-1:0]   elapsed_r, elapsed_nxt;
  logic [MS_W-1:0]   dur_r, dur_nxt;
  logic signed [7:0] fr_r, fr_nxt, fl_r, fl_nxt, br_r, br_nxt, bl_r, bl_nxt;
  logic [7:0]        light_r, light_nxt;

  logic [6:0]         eff_len;
  logic [6:0]         next_step;
  logic [MS_W-1:0]    elapsed_inc;
  logic               tick_done;
  logic               last_step;
  logic               mem_we;
  logic [AW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  entry_t             rd_entry;
  entry_t             wr_entry;
  logic signed [7:0]  sp, sn;

  assign eff_len     = (len_r > DEPTH_CAP) ? DEPTH_CAP : len_r;
  assign next_step   = {1'b0, step_r} + 7'd1;
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 18'd1;
  assign tick_done   = (elapsed_inc >= dur_r);
  assign last_step   = (next_step >= eff_len);

  assign status.advance  = running_r && tick_done && !last_step;
  assign status.zero_len = (eff_len == 7'd0);

  assign wr_entry = '{kind: entry_kind, speed: entry_speed, seconds: entry_seconds};
  assign mem_we   = cmd.write && !running_r && ({3'b000, entry_index} < DEPTH_LIM);
  assign rd_addr  = cmd.start ? '0 : next_step[AW-1:0];

  tmpp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_prog_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (entry_index[AW-1:0]),
    .wdata (wr_entry),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_entry = entry_t'(rd_data);
  assign sp       = signed'({1'b0, rd_entry.speed});
  assign sn       = -sp;

  always_comb begin
    len_nxt     = len_r;
    running_nxt = running_r;
    step_nxt    = step_r;
    elapsed_nxt = elapsed_r;
    dur_nxt     = dur_r;
    fr_nxt      = fr_r;
    fl_nxt      = fl_r;
    br_nxt      = br_r;
    bl_nxt      = bl_r;
    light_nxt   = light_r;

    if (cfg_we) begin
      len_nxt = cfg_program_length;
    end

    if (cmd.start) begin
      step_nxt    = '0;
      elapsed_nxt = '0;
      running_nxt = !status.zero_len;
    end

    if (cmd.stop) begin
      running_nxt = 1'b0;
    end

    if (cmd.tick && running_r) begin
      elapsed_nxt = elapsed_inc;
      if (tick_done) begin
        if (last_step) begin
          running_nxt = 1'b0;
        end else begin
          step_nxt    = next_step[5:0];
          elapsed_nxt = '0;
        end
      end
    end

    if (cmd.apply) begin
      dur_nxt = 18'(rd_entry.seconds) * MS_PER_SECOND;
      unique case (rd_entry.kind)
        KIND_FORWARD: begin
          fr_nxt = sp; fl_nxt = sp; br_nxt = sp; bl_nxt = sp;
        end
        KIND_BACKWARD: begin
          fr_nxt = sn; fl_nxt = sn; br_nxt = sn; bl_nxt = sn;
        end
        KIND_LEFT: begin
          fr_nxt = sp; fl_nxt = sn; br_nxt = sp; bl_nxt = sn;
        end
        KIND_RIGHT: begin
          fr_nxt = sn; fl_nxt = sp; br_nxt = sn; bl_nxt = sp;
        end
        KIND_LIGHT_ON:  light_nxt = LIGHT_ON_LEVEL;
        KIND_LIGHT_OFF: light_nxt = 8'd0;
        default: ; // pause
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      running_r <= 1'b0;
      step_r    <= '0;
      elapsed_r <= '0;
      fr_r      <= '0;
      fl_r      <= '0;
      br_r      <= '0;
      bl_r      <= '0;
      light_r   <= '0;
    end else begin
      len_r     <= len_nxt;
      running_r <= running_nxt;
      step_r    <= step_nxt;
      elapsed_r <= elapsed_nxt;
      fr_r      <= fr_nxt;
      fl_r      <= fl_nxt;
      br_r      <= br_nxt;
      bl_r      <= bl_nxt;
      light_r   <= light_nxt;
    end
  end

  // entry duration is only read while running, after an apply
  always_ff @(posedge clk) begin
    dur_r <= dur_nxt;
  end

  assign drive_front_right = fr_r;
  assign drive_front_left  = fl_r;
  assign drive_back_right  = br_r;
  assign drive_back_left   = bl_r;
  assign headlight_level   = light_r;
  assign step_index        = step_r;
  assign finished          = !running_r;

endmodule

### src/timed_motion_program_player.sv
// Top level of the timed motion program player.
//
// Usage: program entries go in as input transactions with in_mode = write,
// one entry per transaction, while no run is active. The program length is
// set through the cfg_ channel (always ready); the user must set it
// only while the block is idle, which the block itself does not enforce.
// A start transaction plays entry 0; each tick transaction counts one
// millisecond and steps to the next entry once the entry's seconds * 1000
// have elapsed, or ends the run after the last entry. Stop halts the run
// and leaves the drives as they are. Every input transaction yields exactly
// one output transaction carrying the four wheel drives, the headlight
// level, the step and finished flag. Write, stop, a start with a zero
// program length and a tick that stays on its entry give the result in
// the cycle after acceptance; any other start or tick first passes
// through S_APPLY for the registered read of the program RAM. One item is
// in flight at a time. Reset clears the drives, headlight, step, length
// and run state; program RAM contents are left unknown until written.
// Stall: while a result is held in the output register, in_ready stays low;
// a new transaction may be accepted in the same cycle the result is taken.
module timed_motion_program_player
  import tmpp_pkg::*;
#(
  parameter int unsigned PROGRAM_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [5:0]        in_entry_index,
  input  logic [2:0]        in_entry_kind,
  input  logic [6:0]        in_entry_speed,
  input  logic [7:0]        in_entry_seconds,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] out_drive_front_right,
  output logic signed [7:0] out_drive_front_left,
  output logic signed [7:0] out_drive_back_right,
  output logic signed [7:0] out_drive_back_left,
  output logic [7:0]        out_headlight_level,
  output logic [5:0]        out_step_index,
  output logic              out_finished,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [6:0]        cfg_program_length
);

  cmd_t    cmd;
  status_t status;

  // the length register takes every write at once, so the port never stalls
  assign cfg_ready = 1'b1;

  tmpp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // State registers double as the output payload: they only change when a
  // new transaction is accepted or applied, which is never before the last result left.
  tmpp_dp #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_program_length (cfg_program_length),
    .entry_index        (in_entry_index),
    .entry_kind         (in_entry_kind),
    .entry_speed        (in_entry_speed),
    .entry_seconds      (in_entry_seconds),
    .drive_front_right  (out_drive_front_right),
    .drive_front_left   (out_drive_front_left),
    .drive_back_right   (out_drive_back_right),
    .drive_back_left    (out_drive_back_left),
    .headlight_level    (out_headlight_level),
    .step_index         (out_step_index),
    .finished           (out_finished)
  );

endmodule
